FILE: src/isq_pkg.sv
// Package with field widths, operation codes and status codes of the indexed sequence store.
package isq_pkg;

    // Field widths of the request and response words.
    localparam int FUNC_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 4;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // Operation codes carried in the func field.
    localparam logic [FUNC_W-1:0] FUNC_INSERT  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_READ    = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DELETE  = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REVERSE = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_DUMP    = 3'd4;

    // Status codes carried in the response word.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

FILE: src/isq_ifs.sv
// Handshake interfaces for the request and response channels of the indexed sequence store.
interface isq_req_if
    import isq_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    value_t            value;
    logic [POS_W-1:0]  position;

    modport source(output valid, output func, output value, output position, input ready);
    modport sink(input valid, input func, input value, input position, output ready);
endinterface

interface isq_rsp_if
    import isq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    value_t              data_out;
    logic [OCC_W-1:0]    occupancy;
    logic                last;

    modport source(output valid, output status, output data_out, output occupancy,
                   output last, input ready);
    modport sink(input valid, input status, input data_out, input occupancy,
                 input last, output ready);
endinterface

FILE: src/indexed_sequence_store.sv
// Top level of the indexed sequence store: sequencer, shared address unit and entry RAM.
//
// The store keeps up to DEPTH signed 32-bit words in a circular RAM, with a head pointer
// and a direction bit that give the physical place of every logical index; one shared
// modular add/subtract unit turns an index into a RAM address for every access. A request
// word is taken only while the sequencer is idle, and a finished response word may still
// wait on the output register while the next request is taken. A delete moves each entry
// behind the gap forward by one place, with one RAM read and one RAM write per entry. A
// dump sends one word per entry, by one RAM read, one data capture and one output load
// each, and waits while the sink stalls. Entries hold no reset value, so there is no
// clearing pass after reset.
module indexed_sequence_store
    import isq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    isq_req_if.sink   req,
    isq_rsp_if.source rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    // Sequencer states.
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RWAIT = 3'd2;
    localparam logic [2:0] S_DRD   = 3'd3;
    localparam logic [2:0] S_DWR   = 3'd4;
    localparam logic [2:0] S_PRD   = 3'd5;
    localparam logic [2:0] S_PWAIT = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    // Control state.
    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       head_reg, head_next;
    logic                dir_reg, dir_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                more_reg, more_next;
    logic                out_valid_reg, out_valid_next;

    // Payload state.
    logic [FUNC_W-1:0]   func_reg, func_next;
    value_t              value_reg, value_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    value_t              res_data_reg, res_data_next;
    logic                res_last_reg, res_last_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    value_t              out_data_reg, out_data_next;
    logic [OCC_W-1:0]    out_occ_reg, out_occ_next;
    logic                out_last_reg, out_last_next;

    // Shared address unit and RAM signals.
    logic                u_back;
    logic [AW-1:0]       u_off;
    logic [AW-1:0]       u_addr;
    logic [AW:0]         u_sum;
    logic [AW:0]         u_diff;
    logic                ram_we;
    value_t              ram_wdata;
    logic [VALUE_W-1:0]  ram_rdata;

    logic [7:0]          pos_ext;
    logic [7:0]          cnt_ext;
    logic                bad_index;
    logic                is_full;

    assign pos_ext   = 8'(pos_reg);
    assign cnt_ext   = 8'(count_reg);
    assign bad_index = (pos_ext >= cnt_ext);
    assign is_full   = (count_reg == DEPTH_C);

    // Logical index to physical address: head plus or minus offset, modulo DEPTH.
    always_comb
    begin
        u_sum  = {1'b0, head_reg} + {1'b0, u_off};
        u_diff = {1'b0, head_reg} - {1'b0, u_off};
        if (!u_back)
        begin
            u_addr = (u_sum >= DEPTH_W) ? AW'(u_sum - DEPTH_W) : AW'(u_sum);
        end
        else
        begin
            u_addr = u_diff[AW] ? AW'(u_diff + DEPTH_W) : AW'(u_diff);
        end
    end

    assign ram_wdata = (state_reg == S_EXEC) ? value_reg : value_t'(ram_rdata);

    isq_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(u_addr),
        .wdata(ram_wdata),
        .raddr(u_addr),
        .rdata(ram_rdata)
    );

    // Sequencer and datapath next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        dir_next        = dir_reg;
        count_next      = count_reg;
        more_next       = more_reg;
        func_next       = func_reg;
        value_next      = value_reg;
        pos_next        = pos_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_last_next   = res_last_reg;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_occ_next    = out_occ_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        u_back          = dir_reg;
        u_off           = idx_reg;
        ram_we          = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    value_next = req.value;
                    pos_next   = req.position;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                more_next       = 1'b0;
                res_last_next   = 1'b1;
                res_data_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_EMIT;
                case (func_reg)
                    FUNC_INSERT:
                    begin
                        if (is_full)
                        begin
                            res_status_next = ST_FULL;
                        end
                        else
                        begin
                            // The new front sits one place before the head.
                            u_back     = !dir_reg;
                            u_off      = AW'(1);
                            ram_we     = 1'b1;
                            head_next  = u_addr;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    FUNC_READ:
                    begin
                        if (bad_index)
                        begin
                            res_status_next = ST_BAD_INDEX;
                        end
                        else
                        begin
                            u_off      = AW'(pos_reg);
                            state_next = S_RWAIT;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (bad_index)
                        begin
                            res_status_next = ST_BAD_INDEX;
                        end
                        else if (pos_ext + 8'd1 == cnt_ext)
                        begin
                            count_next = count_reg - CW'(1);
                        end
                        else
                        begin
                            idx_next   = AW'(pos_reg);
                            state_next = S_DRD;
                        end
                    end
                    FUNC_REVERSE:
                    begin
                        // The back entry becomes the head and the walk direction flips.
                        if (count_reg > CW'(1))
                        begin
                            u_off     = AW'(count_reg - CW'(1));
                            head_next = u_addr;
                            dir_next  = !dir_reg;
                        end
                    end
                    FUNC_DUMP:
                    begin
                        if (count_reg == '0)
                        begin
                            res_status_next = ST_EMPTY;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = S_PRD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_RWAIT:
            begin
                res_data_next = value_t'(ram_rdata);
                state_next    = S_EMIT;
            end

            S_DRD:
            begin
                u_off      = idx_reg + AW'(1);
                state_next = S_DWR;
            end

            S_DWR:
            begin
                // Move the entry behind the gap forward by one place.
                ram_we = 1'b1;
                if (CW'(idx_reg) + CW'(2) == count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + AW'(1);
                    state_next = S_DRD;
                end
            end

            S_PRD:
            begin
                state_next = S_PWAIT;
            end

            S_PWAIT:
            begin
                res_data_next   = value_t'(ram_rdata);
                res_status_next = ST_OK;
                res_last_next   = (CW'(idx_reg) + CW'(1) == count_reg);
                more_next       = !(CW'(idx_reg) + CW'(1) == count_reg);
                state_next      = S_EMIT;
            end

            S_EMIT:
            begin
                // Load the output register once it is free or being drained.
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_data_next   = res_data_reg;
                    out_occ_next    = OCC_W'(count_reg);
                    out_last_next   = res_last_reg;
                    if (more_reg)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_PRD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            dir_reg       <= 1'b0;
            count_reg     <= '0;
            more_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            dir_reg       <= dir_next;
            count_reg     <= count_next;
            more_reg      <= more_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        value_reg      <= value_next;
        pos_reg        <= pos_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_last_reg   <= res_last_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_occ_reg    <= out_occ_next;
        out_last_reg   <= out_last_next;
    end

    assign req.ready     = (state_reg == S_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.data_out  = out_data_reg;
    assign rsp.occupancy = out_occ_reg;
    assign rsp.last      = out_last_reg;

`ifndef SYNTHESIS
    // The entry count never passes the capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("entry count exceeds capacity");

    // The entry count moves by at most one per cycle.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
            ((count_reg == $past(count_reg) + CW'(1)) ||
             (count_reg + CW'(1) == $past(count_reg))))
        else $error("entry count jumped by more than one");

    // An empty-dump word carries zero data and closes the item.
    a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == ST_EMPTY) |->
            (rsp.data_out == '0 && rsp.last && rsp.occupancy == '0))
        else $error("malformed empty-dump word");
`endif

endmodule

FILE: src/isq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module isq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Synchronous write and registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: verif/indexed_sequence_store_tb.sv
// Self-checking testbench for the indexed sequence store: random and directed request words.
module indexed_sequence_store_tb
    import isq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;
    localparam int N_RANDOM = 195;
    localparam int DRAIN_CYCLES = 64;
    localparam logic [FUNC_W-1:0] FUNC_TOP = '1;

    typedef struct {
        logic [FUNC_W-1:0] func;
        value_t            value;
        logic [POS_W-1:0]  position;
    } op_word_t;

    typedef struct {
        logic [STATUS_W-1:0] status;
        value_t              data;
        logic [OCC_W-1:0]    occ;
        logic                last;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    isq_req_if req();
    isq_rsp_if rsp();

    indexed_sequence_store #(.DEPTH(DEPTH)) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the store contents, updated as request words are taken.
    value_t seq_vals [DEPTH];
    int     seq_count = 0;

    // Request words still to be sent, and response words still owed by the block.
    op_word_t  op_plan [$];
    rsp_word_t owed_words [$];

    // Occupancy as seen by the stimulus planner, ahead of the hardware.
    int plan_count = 0;
    int n_planned = 0;

    int unsigned cyc = 0;
    int send_gap = 0;
    int recv_stall = 0;
    int n_taken = 0;
    int n_words = 0;
    int n_dumps = 0;
    int n_fail = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    op_word_t  next_op;
    rsp_word_t want;

    always #2 clk = ~clk;

    // Idle length for either side: mostly none or short, sometimes long, and calm stretches.
    function automatic int pick_gap();
        int r;
        if (cyc[9:8] == 2'b11)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void owe_word(logic [STATUS_W-1:0] status, value_t data, logic last);
        owed_words.push_back('{status, data, seq_count[OCC_W-1:0], last});
    endfunction

    // Applies one request word to the shadow store and queues the words it must produce.
    function automatic void predict_store_op(logic [FUNC_W-1:0] func, value_t value,
                                             logic [POS_W-1:0] position);
        int p;
        value_t t;
        p = int'(position);
        case (func)
            FUNC_INSERT:
            begin
                if (seq_count >= DEPTH)
                begin
                    owe_word(ST_FULL, '0, 1'b1);
                end
                else
                begin
                    for (int i = seq_count; i > 0; i--)
                        seq_vals[i] = seq_vals[i-1];
                    seq_vals[0] = value;
                    seq_count++;
                    owe_word(ST_OK, '0, 1'b1);
                end
            end
            FUNC_READ:
            begin
                if (p >= seq_count)
                    owe_word(ST_BAD_INDEX, '0, 1'b1);
                else
                    owe_word(ST_OK, seq_vals[p], 1'b1);
            end
            FUNC_DELETE:
            begin
                if (p >= seq_count)
                begin
                    owe_word(ST_BAD_INDEX, '0, 1'b1);
                end
                else
                begin
                    for (int i = p; i + 1 < seq_count; i++)
                        seq_vals[i] = seq_vals[i+1];
                    seq_count--;
                    owe_word(ST_OK, '0, 1'b1);
                end
            end
            FUNC_REVERSE:
            begin
                for (int i = 0; i < seq_count / 2; i++)
                begin
                    t = seq_vals[i];
                    seq_vals[i] = seq_vals[seq_count-1-i];
                    seq_vals[seq_count-1-i] = t;
                end
                owe_word(ST_OK, '0, 1'b1);
            end
            FUNC_DUMP:
            begin
                n_dumps++;
                if (seq_count == 0)
                    owe_word(ST_EMPTY, '0, 1'b1);
                else
                    for (int i = 0; i < seq_count; i++)
                        owe_word(ST_OK, seq_vals[i], i + 1 == seq_count);
            end
            default:
            begin
                // Unused operation codes are dropped without an answer.
            end
        endcase
    endfunction

    // Queues one request word and tracks the occupancy it will leave behind.
    task automatic plan_op(logic [FUNC_W-1:0] func, value_t value, logic [POS_W-1:0] position);
        op_plan.push_back('{func, value, position});
        if (func == FUNC_INSERT && plan_count < DEPTH)
            plan_count++;
        else if (func == FUNC_DELETE && int'(position) < plan_count)
            plan_count--;
        if (func <= FUNC_DUMP)
            n_planned++;
    endtask

    function automatic value_t pick_value();
        case ($urandom_range(0, 19))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a held index, sometimes any index so that bad indexes keep appearing.
    function automatic logic [POS_W-1:0] pick_pos();
        if (plan_count > 0 && $urandom_range(0, 4) != 0)
            return POS_W'($urandom_range(0, plan_count - 1));
        return POS_W'($urandom_range(0, DEPTH - 1));
    endfunction

    task automatic plan_fill();
        while (plan_count < DEPTH)
            plan_op(FUNC_INSERT, pick_value(), '0);
        repeat ($urandom_range(1, 2))
            plan_op(FUNC_INSERT, pick_value(), '0);
        plan_op(FUNC_READ, '0, POS_W'(DEPTH - 1));
    endtask

    // Short directed opening: empty store, extreme values, every operation, unused codes.
    task automatic plan_directed();
        plan_op(FUNC_DUMP, '0, '0);
        plan_op(FUNC_READ, '0, '0);
        plan_op(FUNC_DELETE, '0, '0);
        plan_op(FUNC_REVERSE, '0, '0);
        plan_op(FUNC_INSERT, 32'h7FFF_FFFF, '0);
        plan_op(FUNC_REVERSE, '0, '0);
        plan_op(FUNC_READ, '0, '0);
        plan_op(FUNC_INSERT, 32'h8000_0000, '0);
        plan_op(FUNC_INSERT, '1, '0);
        plan_op(FUNC_INSERT, '0, '0);
        plan_op(FUNC_INSERT, 32'h5A5A_A5A5, '0);
        plan_op(FUNC_READ, '0, POS_W'(4));
        plan_op(FUNC_READ, '0, POS_W'(5));
        plan_op(FUNC_READ, '0, '1);
        plan_op(FUNC_DELETE, '0, POS_W'(2));
        plan_op(FUNC_DELETE, '0, '0);
        plan_op(FUNC_DELETE, '0, POS_W'(2));
        plan_op(FUNC_REVERSE, '0, '0);
        plan_op(FUNC_DUMP, '0, '0);
        for (int f = int'(FUNC_DUMP) + 1; f <= int'(FUNC_TOP); f++)
            plan_op(FUNC_W'(f), $urandom, POS_W'($urandom));
    endtask

    // Random part: mixed single words, fill bursts that run past full, drain bursts and reverse-dump pairs.
    task automatic plan_random();
        int start;
        int r;
        start = n_planned;
        plan_fill();
        while (n_planned - start < N_RANDOM)
        begin
            r = $urandom_range(0, 9);
            if (r < 5)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    plan_op(FUNC_INSERT, pick_value(), POS_W'($urandom));
                else if (r < 55)
                    plan_op(FUNC_READ, $urandom, pick_pos());
                else if (r < 75)
                    plan_op(FUNC_DELETE, $urandom, pick_pos());
                else if (r < 85)
                    plan_op(FUNC_REVERSE, $urandom, POS_W'($urandom));
                else if (r < 93)
                    plan_op(FUNC_DUMP, $urandom, POS_W'($urandom));
                else
                    plan_op(FUNC_W'($urandom_range(int'(FUNC_DUMP) + 1, int'(FUNC_TOP))),
                            $urandom, POS_W'($urandom));
            end
            else if (r < 7)
            begin
                plan_fill();
            end
            else if (r < 9)
            begin
                repeat ($urandom_range(1, plan_count + 1))
                    plan_op(FUNC_DELETE, $urandom, pick_pos());
            end
            else
            begin
                plan_op(FUNC_REVERSE, $urandom, POS_W'($urandom));
                plan_op(FUNC_DUMP, $urandom, POS_W'($urandom));
            end
        end
    endtask

    // Request driver: holds a word until taken, then waits out a random gap.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req.valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_store_op(req.func, req.value, req.position);
                n_taken++;
            end
            if (req.valid && !req.ready)
            begin
                // Word not yet taken: keep it on the bus.
            end
            else if (send_gap > 0)
            begin
                req.valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (op_plan.size() > 0)
            begin
                next_op = op_plan.pop_front();
                req.valid <= 1'b1;
                req.func <= next_op.func;
                req.value <= next_op.value;
                req.position <= next_op.position;
                send_gap <= pick_gap();
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // Response monitor: checks every taken word against the oldest owed word.
    always @(posedge clk)
    begin
        cyc++;
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            recv_stall <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                n_words++;
                if (owed_words.size() == 0)
                begin
                    $error("response word with none owed: status %0d data_out %0d",
                           rsp.status, rsp.data_out);
                    n_fail++;
                end
                else
                begin
                    want = owed_words.pop_front();
                    status_seen[want.status]++;
                    if (rsp.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, rsp.status);
                        n_fail++;
                    end
                    if (rsp.data_out !== want.data)
                    begin
                        $error("data_out: expected %0d, got %0d", want.data, rsp.data_out);
                        n_fail++;
                    end
                    if (rsp.occupancy !== want.occ)
                    begin
                        $error("occupancy: expected %0d, got %0d", want.occ, rsp.occupancy);
                        n_fail++;
                    end
                    if (rsp.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, rsp.last);
                        n_fail++;
                    end
                end
            end
            if (recv_stall > 0)
            begin
                rsp.ready <= 1'b0;
                recv_stall <= recv_stall - 1;
            end
            else
            begin
                rsp.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    recv_stall <= pick_gap();
            end
        end
    end

    // Sequence of the run: reset, send everything, wait for the last owed word.
    initial
    begin
        req.valid = 1'b0;
        req.func = FUNC_INSERT;
        req.value = '0;
        req.position = '0;
        rsp.ready = 1'b0;
        plan_directed();
        plan_random();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (op_plan.size() > 0 || req.valid)
            @(posedge clk);
        while (owed_words.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d request words (%0d dumps) and checked %0d response words.",
                 n_taken, n_dumps, n_words);
        $display("Seen: %0d refused inserts on a full store, %0d bad indexes, %0d empty dumps.",
                 status_seen[ST_FULL], status_seen[ST_BAD_INDEX], status_seen[ST_EMPTY]);
        if (n_fail == 0)
            $display("PASS indexed_sequence_store");
        else
            $display("FAIL indexed_sequence_store");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #5000000;
        $display("FAIL indexed_sequence_store");
        $finish;
    end

endmodule
